### rtl/core/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply block.
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_VALUE_BITS = 16;

  localparam int VEC_INDEX_BITS = 10;
  localparam int COL_W          = 11;
  localparam int ROW_W          = 16;
  localparam int ACC_W          = 48;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 1;

  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH = 4;

  localparam logic                   CMD_LOAD     = 1'b0;
  localparam logic                   CMD_MAC      = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_ROWS = 1'b1;

  typedef enum logic {
    OP_LOAD,
    OP_MAC
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [VEC_INDEX_BITS-1:0] vec_index;
    logic [VEC_INDEX_BITS-1:0] quot;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0] num_cols;
    logic [ROW_W-1:0] num_rows;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] row_sum;
    logic [ROW_W-1:0] row_index;
    logic             last_row;
  } result_t;

endpackage

### rtl/core/mvm_fifo.sv
// Small register queue with occupancy count.
`timescale 1ns / 1ps

module mvm_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2,
  parameter int  CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  T                 data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output T                 data_o,
  output logic [CNT_W-1:0] count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T                 data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign data_o  = data_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/mvm_front.sv
// Input side: accepts items, classifies them and queues them for execution.
`timescale 1ns / 1ps

module mvm_front #(
  parameter int MAX_COLS   = mvm_pkg::DEF_MAX_COLS,
  parameter int VALUE_BITS = mvm_pkg::DEF_VALUE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  cmd_i,
  input  logic [mvm_pkg::VEC_INDEX_BITS-1:0]    vec_index_i,
  input  logic signed [VALUE_BITS-1:0]          value_i,
  output logic                                  q_valid_o,
  input  logic                                  q_pop_i,
  output mvm_pkg::item_t                        item_o,
  output logic signed [VALUE_BITS-1:0]          value_o
);

  import mvm_pkg::*;

  localparam int RECIP_SHIFT = 2 * VEC_INDEX_BITS;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + MAX_COLS - 1) / MAX_COLS;
  localparam int PROD_W      = VEC_INDEX_BITS + RECIP_W;

  typedef struct packed {
    item_t                  item;
    logic [VALUE_BITS-1:0]  value;
  } entry_t;

  entry_t            entry_in, entry_out;
  logic [PROD_W-1:0] recip_prod;
  logic              full;

  assign recip_prod = PROD_W'(vec_index_i) * PROD_W'(RECIP_W'(RECIP));

  always_comb begin
    entry_in.item.op        = (cmd_i == CMD_MAC) ? OP_MAC : OP_LOAD;
    entry_in.item.vec_index = vec_index_i;
    entry_in.item.quot      = recip_prod[RECIP_SHIFT +: VEC_INDEX_BITS];
    entry_in.value          = value_i;
  end

  assign in_ready_o = !full;

  mvm_fifo #(
    .T     (entry_t),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (entry_in),
    .full_o  (full),
    .pop_i   (q_pop_i),
    .valid_o (q_valid_o),
    .data_o  (entry_out),
    .count_o ()
  );

  assign item_o  = entry_out.item;
  assign value_o = entry_out.value;

endmodule

### rtl/core/mvm_back.sv
// Execution side: vector store, row counters, multiply-accumulate pipeline, result queue.
`timescale 1ns / 1ps

module mvm_back #(
  parameter int MAX_COLS   = mvm_pkg::DEF_MAX_COLS,
  parameter int VALUE_BITS = mvm_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mvm_pkg::cfg_t                 cfg_i,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  mvm_pkg::item_t                item_i,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mvm_pkg::result_t              result_o
);

  import mvm_pkg::*;

  localparam int  ADDR_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam bit  IDX_WRAP  = (MAX_COLS < (1 << VEC_INDEX_BITS));
  localparam int  OUT_CNT_W = $clog2(OUT_QUEUE_DEPTH + 1);
  localparam int  PEND_W    = OUT_CNT_W + 1;
  localparam int  PROD_W    = 2 * VALUE_BITS;

  logic [VALUE_BITS-1:0]          mem_q [MAX_COLS];
  logic [COL_W-1:0]               col_q, col_d;
  logic [ROW_W-1:0]               row_q, row_d;
  logic [ACC_W-1:0]               acc_q, acc_d;
  logic [COL_W-1:0]               eff_cols;
  logic [COL_W:0]                 col_next;
  logic [ROW_W-1:0]               row_next;
  logic                           row_end, row_last;
  logic                           is_mac, do_load, do_mac;
  logic [31:0]                    quot_mul;
  logic [VEC_INDEX_BITS-1:0]      idx_rem;
  logic [ADDR_W-1:0]              wr_addr, rd_addr;

  logic                           s1_valid_q, s1_end_q, s1_last_q;
  logic [ROW_W-1:0]               s1_row_q;
  logic signed [VALUE_BITS-1:0]   s1_a_q, s1_x_q;
  logic                           s2_valid_q, s2_end_q, s2_last_q;
  logic [ROW_W-1:0]               s2_row_q;
  logic signed [PROD_W-1:0]       s2_prod_q;
  logic [ACC_W-1:0]               sum;

  logic [OUT_CNT_W-1:0]           out_cnt;
  logic [PEND_W-1:0]              pending;
  logic                           out_full;
  logic                           push_res;
  result_t                        res_in;

  always_comb begin
    if (cfg_i.num_cols == '0) begin
      eff_cols = COL_W'(1);
    end else if (32'(cfg_i.num_cols) > 32'(MAX_COLS)) begin
      eff_cols = COL_W'(MAX_COLS);
    end else begin
      eff_cols = cfg_i.num_cols;
    end
  end

  assign pending = PEND_W'(out_cnt) + PEND_W'(s1_valid_q && s1_end_q)
                 + PEND_W'(s2_valid_q && s2_end_q);
  assign q_pop_o = q_valid_i && (pending < PEND_W'(OUT_QUEUE_DEPTH));
  assign is_mac  = (item_i.op == OP_MAC);
  assign do_load = q_pop_o && !is_mac;
  assign do_mac  = q_pop_o && is_mac;

  assign col_next = {1'b0, col_q} + 1'b1;
  assign row_end  = (col_next >= {1'b0, eff_cols});
  assign row_next = row_q + 1'b1;
  assign row_last = (row_next == cfg_i.num_rows);

  assign quot_mul = 32'(item_i.quot) * 32'(MAX_COLS);
  assign idx_rem  = VEC_INDEX_BITS'(32'(item_i.vec_index) - quot_mul);
  assign wr_addr  = IDX_WRAP ? ADDR_W'(idx_rem) : ADDR_W'(item_i.vec_index);
  assign rd_addr  = ADDR_W'(col_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (do_mac) begin
      if (row_end) begin
        col_d = '0;
        row_d = row_last ? '0 : row_next;
      end else begin
        col_d = col_next[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem_q[wr_addr] <= value_i;
    end
    if (do_mac) begin
      s1_x_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      acc_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      acc_q      <= acc_d;
      s1_valid_q <= do_mac;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_mac) begin
      s1_a_q    <= value_i;
      s1_end_q  <= row_end;
      s1_last_q <= row_last;
      s1_row_q  <= row_q;
    end
    if (s1_valid_q) begin
      s2_prod_q <= s1_a_q * s1_x_q;
      s2_end_q  <= s1_end_q;
      s2_last_q <= s1_last_q;
      s2_row_q  <= s1_row_q;
    end
  end

  assign sum = acc_q + ACC_W'(s2_prod_q);

  always_comb begin
    acc_d = acc_q;
    if (s2_valid_q) begin
      acc_d = s2_end_q ? '0 : sum;
    end
  end

  assign push_res         = s2_valid_q && s2_end_q;
  assign res_in.row_sum   = sum;
  assign res_in.row_index = s2_row_q;
  assign res_in.last_row  = s2_last_q;

  mvm_fifo #(
    .T     (result_t),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_res),
    .data_i  (res_in),
    .full_o  (out_full),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (result_o),
    .count_o (out_cnt)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_res |-> !out_full)
    else $error("result queue overrun");

endmodule

### rtl/core/matrix_vector_multiply.sv
// Matrix-vector multiply: vector load, streamed row dot products, 48-bit row sums.
// Throughput: one item per cycle; execution pauses while four row sums await transfer.
// A row's last element passes command queue, s1 and s2; its sum is then queued for output.
// A load is visible to matrix elements transferred in any later cycle.
// Reset: counters and accumulator clear, num_cols and num_rows return to 1;
// the vector store is not cleared and holds undefined data until loaded.
`timescale 1ns / 1ps

module matrix_vector_multiply #(
  parameter int MAX_COLS   = mvm_pkg::DEF_MAX_COLS,
  parameter int VALUE_BITS = mvm_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mvm_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [mvm_pkg::VEC_INDEX_BITS-1:0]  vec_index_i,
  input  logic signed [VALUE_BITS-1:0]        value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mvm_pkg::ACC_W-1:0]    row_sum_o,
  output logic [mvm_pkg::ROW_W-1:0]           row_index_o,
  output logic                                last_row_o
);

  import mvm_pkg::*;

  cfg_t                          cfg_q;
  logic                          q_valid, q_pop;
  item_t                         q_item;
  logic signed [VALUE_BITS-1:0]  q_value;
  result_t                       result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_cols <= COL_W'(1);
      cfg_q.num_rows <= ROW_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_NUM_COLS) begin
        cfg_q.num_cols <= cfg_wdata_i[COL_W-1:0];
      end
      if (cfg_index_i == CFG_NUM_ROWS) begin
        cfg_q.num_rows <= cfg_wdata_i[ROW_W-1:0];
      end
    end
  end

  mvm_front #(
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .vec_index_i (vec_index_i),
    .value_i     (value_i),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .item_o      (q_item),
    .value_o     (q_value)
  );

  mvm_back #(
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .item_i      (q_item),
    .value_i     (q_value),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign row_sum_o   = result.row_sum;
  assign row_index_o = result.row_index;
  assign last_row_o  = result.last_row;

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      q_valid && !q_pop |=> q_valid)
    else $error("queued command lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && last_row_o |-> (row_index_o + 1'b1) == cfg_q.num_rows)
    else $error("last-row flag on wrong row");

endmodule

### test/mvm_checker.sv
// Checker for matrix_vector_multiply: predicts row sums from observed transfers and compares them.
`timescale 1ns / 1ps

module mvm_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mvm_pkg::CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic                                   cmd_i,
  input  logic [mvm_pkg::VEC_INDEX_BITS-1:0]     vec_index_i,
  input  logic signed [mvm_pkg::DEF_VALUE_BITS-1:0] value_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic signed [mvm_pkg::ACC_W-1:0]       row_sum_i,
  input  logic [mvm_pkg::ROW_W-1:0]              row_index_i,
  input  logic                                   last_row_i,
  output int                                     errors_o,
  output int                                     pending_o,
  output int                                     rows_checked_o,
  output int                                     row_pos_o
);

  localparam int MAX_COLS   = mvm_pkg::DEF_MAX_COLS;
  localparam int VB         = mvm_pkg::DEF_VALUE_BITS;

  logic signed [VB-1:0]         vec_mem [MAX_COLS];
  logic [mvm_pkg::COL_W-1:0]    col_pos;
  logic [mvm_pkg::ACC_W-1:0]    row_acc;
  logic [mvm_pkg::ROW_W-1:0]    row_pos;
  logic [mvm_pkg::COL_W-1:0]    cols_reg;
  logic [mvm_pkg::ROW_W-1:0]    rows_reg;
  mvm_pkg::result_t             sums_due [$];

  initial begin
    errors_o       = 0;
    pending_o      = 0;
    rows_checked_o = 0;
    row_pos_o      = 0;
    for (int i = 0; i < MAX_COLS; i++) begin
      vec_mem[i] = '0;
    end
  end

  function automatic int row_length();
    if (cols_reg == 0) begin
      return 1;
    end
    if (int'(cols_reg) > MAX_COLS) begin
      return MAX_COLS;
    end
    return int'(cols_reg);
  endfunction

  task automatic flag(input string what, input longint want, input longint got);
    errors_o++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic check_row(input logic [mvm_pkg::ACC_W-1:0] sum,
                           input logic [mvm_pkg::ROW_W-1:0] idx,
                           input logic last);
    mvm_pkg::result_t want;
    if (sums_due.size() == 0) begin
      errors_o++;
      $display("%0t: unexpected row sum, expected none, got sum %0d row %0d last %0b",
               $time, longint'($signed(sum)), idx, last);
      return;
    end
    want = sums_due.pop_front();
    rows_checked_o++;
    if (sum !== want.row_sum) begin
      flag("row_sum", longint'($signed(want.row_sum)), longint'($signed(sum)));
    end
    if (idx !== want.row_index) begin
      flag("row_index", longint'(want.row_index), longint'(idx));
    end
    if (last !== want.last_row) begin
      flag("last_row", longint'(want.last_row), longint'(last));
    end
  endtask

  task automatic take_item(input logic cmd, input logic [mvm_pkg::VEC_INDEX_BITS-1:0] idx,
                           input logic signed [VB-1:0] val);
    logic signed [2*VB-1:0]    prod;
    logic [mvm_pkg::ROW_W-1:0] next_row;
    mvm_pkg::result_t          due;
    if (cmd == mvm_pkg::CMD_LOAD) begin
      vec_mem[int'(idx) % MAX_COLS] = val;
      return;
    end
    prod    = val * vec_mem[int'(col_pos) % MAX_COLS];
    row_acc = row_acc + {{(mvm_pkg::ACC_W-2*VB){prod[2*VB-1]}}, prod};
    col_pos = col_pos + 1'b1;
    if (int'(col_pos) < row_length()) begin
      return;
    end
    next_row      = row_pos + 1'b1;
    due.row_sum   = row_acc;
    due.row_index = row_pos;
    due.last_row  = (next_row == rows_reg);
    sums_due.push_back(due);
    row_acc = '0;
    col_pos = '0;
    row_pos = due.last_row ? '0 : next_row;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos  = '0;
      row_acc  = '0;
      row_pos  = '0;
      cols_reg = 1;
      rows_reg = 1;
      sums_due.delete();
      pending_o = 0;
      row_pos_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == mvm_pkg::CFG_NUM_COLS) begin
          cols_reg = cfg_wdata_i[mvm_pkg::COL_W-1:0];
        end else if (cfg_index_i == mvm_pkg::CFG_NUM_ROWS) begin
          rows_reg = cfg_wdata_i[mvm_pkg::ROW_W-1:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        check_row(row_sum_i, row_index_i, last_row_i);
      end
      if (in_valid_i && in_ready_i) begin
        take_item(cmd_i, vec_index_i, value_i);
      end
      pending_o = sums_due.size();
      row_pos_o = int'(row_pos);
    end
  end

endmodule

### test/tb_top.sv
// Top-level testbench for matrix_vector_multiply: stimulus, idling, drain and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_COLS     = mvm_pkg::DEF_MAX_COLS;
  localparam int VB           = mvm_pkg::DEF_VALUE_BITS;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 400;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [mvm_pkg::CFG_INDEX_W-1:0]     cfg_index;
  logic [mvm_pkg::CFG_DATA_W-1:0]      cfg_wdata;
  logic                                in_valid;
  logic                                in_ready;
  logic                                in_cmd;
  logic [mvm_pkg::VEC_INDEX_BITS-1:0]  in_vec_index;
  logic signed [VB-1:0]                in_value;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [mvm_pkg::ACC_W-1:0]    out_row_sum;
  logic [mvm_pkg::ROW_W-1:0]           out_row_index;
  logic                                out_last_row;

  int          errors;
  int          pending;
  int          rows_checked;
  int          row_pos;
  int unsigned cycle_count;
  int          items_sent;
  int          settings_used;
  bit          gaps_on;
  bit          loaded [MAX_COLS];

  matrix_vector_multiply DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (in_cmd),
    .vec_index_i (in_vec_index),
    .value_i     (in_value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .row_sum_o   (out_row_sum),
    .row_index_o (out_row_index),
    .last_row_o  (out_last_row)
  );

  mvm_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (in_cmd),
    .vec_index_i    (in_vec_index),
    .value_i        (in_value),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .row_sum_i      (out_row_sum),
    .row_index_i    (out_row_index),
    .last_row_i     (out_last_row),
    .errors_o       (errors),
    .pending_o      (pending),
    .rows_checked_o (rows_checked),
    .row_pos_o      (row_pos)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = ~clk;
    end
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("[matrix_vector_multiply] ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts while gaps are on, otherwise always ready.
  initial begin
    int burst;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(3) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(13, 1);
      end else begin
        out_ready <= 1'b1;
        burst = $urandom_range(20, 1);
      end
      repeat (burst) @(posedge clk);
    end
  end

  function automatic logic signed [VB-1:0] pick_value();
    int r;
    r = $urandom_range(15);
    case (r)
      0, 1:    return 16'h8000;
      2, 3:    return 16'h7fff;
      4:       return 16'h0000;
      5:       return 16'hffff;
      default: return VB'($urandom);
    endcase
  endfunction

  function automatic int pick_cols();
    int r;
    r = $urandom_range(19);
    if (r < 11) return $urandom_range(6, 1);
    if (r < 16) return $urandom_range(40, 7);
    if (r < 18) return 0;
    return $urandom_range(120, 41);
  endfunction

  function automatic int pick_rows();
    int r;
    r = $urandom_range(19);
    if (r < 10) return $urandom_range(5, 1);
    if (r < 15) return $urandom_range(300, 6);
    if (r < 17) return 0;
    if (r < 19) return 65535;
    return $urandom_range(65535);
  endfunction

  // Hold valid and payload until the transfer; an optional gap comes first.
  task automatic send_item(input logic cmd, input logic [mvm_pkg::VEC_INDEX_BITS-1:0] idx,
                           input logic signed [VB-1:0] val);
    int gap;
    if (gaps_on && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(13, 1);
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_vec_index <= idx;
    in_value     <= val;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (cmd == mvm_pkg::CMD_LOAD) begin
      loaded[idx] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic send_element();
    send_item(mvm_pkg::CMD_MAC, mvm_pkg::VEC_INDEX_BITS'($urandom_range(MAX_COLS - 1)),
              pick_value());
  endtask

  // Drop valid and wait until every pending row sum has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drain, then write both registers.
  task automatic write_cfg(input int cols, input int rows);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= mvm_pkg::CFG_NUM_COLS;
    cfg_wdata <= mvm_pkg::CFG_DATA_W'(cols);
    @(posedge clk);
    cfg_index <= mvm_pkg::CFG_NUM_ROWS;
    cfg_wdata <= mvm_pkg::CFG_DATA_W'(rows);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic configure(input int cols, input int rows);
    int span;
    write_cfg(cols, rows);
    span = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
    for (int i = 0; i < span; i++) begin
      if (!loaded[i]) begin
        send_item(mvm_pkg::CMD_LOAD, mvm_pkg::VEC_INDEX_BITS'(i), pick_value());
      end
    end
  endtask

  initial begin
    int n;
    int start;
    int random_items;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = mvm_pkg::CFG_NUM_COLS;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_cmd       = mvm_pkg::CMD_LOAD;
    in_vec_index = '0;
    in_value     = '0;
    gaps_on      = 1'b1;
    items_sent    = 0;
    settings_used = 0;
    random_items  = 0;
    for (int i = 0; i < MAX_COLS; i++) begin
      loaded[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Extreme vector entries, including the top store index.
    send_item(mvm_pkg::CMD_LOAD, 10'd0, 16'h8000);
    send_item(mvm_pkg::CMD_LOAD, 10'd1, 16'h7fff);
    send_item(mvm_pkg::CMD_LOAD, 10'd2, 16'hffff);
    send_item(mvm_pkg::CMD_LOAD, 10'd3, 16'h1000);
    send_item(mvm_pkg::CMD_LOAD, 10'h3ff, 16'h5555);
    configure(4, 3);
    repeat (4) send_item(mvm_pkg::CMD_MAC, 10'h3ff, 16'h8000);
    repeat (4) send_item(mvm_pkg::CMD_MAC, 10'h000, 16'h7fff);
    send_item(mvm_pkg::CMD_MAC, 10'h000, 16'h0001);
    // overwrite an entry while its row is open
    send_item(mvm_pkg::CMD_LOAD, 10'd3, 16'h8000);
    send_item(mvm_pkg::CMD_MAC, 10'h000, 16'hffff);
    send_item(mvm_pkg::CMD_MAC, 10'h000, 16'h1000);
    send_item(mvm_pkg::CMD_MAC, 10'h000, 16'h0000);
    // zero columns behaves as one
    configure(0, 1);
    repeat (2) send_item(mvm_pkg::CMD_MAC, 10'h155, 16'h7fff);
    // shrink the row length part-way through a row
    configure(6, 4);
    repeat (3) send_element();
    configure(2, 4);
    send_element();

    while (random_items < RANDOM_ITEMS) begin
      start   = items_sent;
      gaps_on = ($urandom_range(4) != 0);
      configure(pick_cols(), pick_rows());
      n = $urandom_range(80, 20);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(6) == 0) begin
          send_item(mvm_pkg::CMD_LOAD,
                    mvm_pkg::VEC_INDEX_BITS'($urandom_range(MAX_COLS - 1)), pick_value());
        end else begin
          send_element();
        end
        if ($urandom_range(60) == 0) begin
          drain();
        end
      end
      random_items += items_sent - start;
    end

    // Close any open row, then an oversized column count ended by a shorter one.
    gaps_on = 1'b1;
    configure(1, 2);
    send_element();
    configure(64, 2);
    write_cfg(2047, 2);
    repeat (50) send_element();
    write_cfg(40, 2);
    send_element();

    // Last row at a high row index and the return to zero, streamed without gaps.
    gaps_on = 1'b0;
    drain();
    configure(1, row_pos + 3);
    repeat (10) send_element();

    drain();
    $display("%0d items transferred under %0d register settings, %0d row sums compared",
             items_sent, settings_used, rows_checked);
    $display("covered extreme operands, loads mid-row, length changes mid-row, row counter return");
    if (errors == 0 && pending == 0) begin
      $display("[matrix_vector_multiply] OK");
    end else begin
      $display("[matrix_vector_multiply] ERROR");
    end
    $finish;
  end

endmodule
